FILE: hw/rtl/tam_pkg.sv
// ----------------------------------------------------------------------------
// tam_pkg
// Shared constants for the thruster allocation mixer: field widths, axis
// scale factors, flag positions, lane order and pipeline stage numbers.
// ----------------------------------------------------------------------------
package tam_pkg;

	localparam int FRAC_BITS_DEF = 8;

	// field widths
	localparam int LEVEL_W  = 8;
	localparam int SIGN_W   = 5;
	localparam int MF_W     = 8;
	localparam int OUT_W    = 9;
	localparam int NUM_AXES = 5;
	localparam int IN_DATA_W  = ((NUM_AXES * LEVEL_W + 7) / 8) * 8;
	localparam logic [MF_W-1:0] MF_RESET = 8'd255;

	// axis scale factors, applied as level * K / LEVEL_DEN
	localparam int K_SURGE_SWAY = 1023;
	localparam int K_YAW_HEAVE  = 510;
	localparam int K_PITCH      = 255;
	localparam int LEVEL_DEN    = 254;
	// fraction bits of the reciprocal constant, enough for an exact floor over 8-bit levels
	localparam int RECIP_SH     = 17;

	// negate flag positions in the sign byte
	localparam int SB_SURGE = 0;
	localparam int SB_SWAY  = 1;
	localparam int SB_PITCH = 2;
	localparam int SB_YAW   = 3;
	localparam int SB_HEAVE = 4;

	// lanes, one per thruster
	localparam int NUM_H     = 4;
	localparam int NUM_V     = 2;
	localparam int NUM_LANES = NUM_H + NUM_V;
	localparam int L_FR = 0;
	localparam int L_FL = 1;
	localparam int L_BR = 2;
	localparam int L_BL = 3;
	localparam int L_V1 = 4;
	localparam int L_V2 = 5;
	localparam int OUT_DATA_W = ((NUM_LANES * OUT_W + 7) / 8) * 8;

	// quotient bits of the desaturation divide, result magnitude never exceeds the thrust cap
	localparam int Q_W = MF_W;

	// pipeline stage numbers
	localparam int ST_SCALE    = 1;
	localparam int ST_SUM      = 2;
	localparam int ST_MAG      = 3;
	localparam int ST_PEAK     = 4;
	localparam int ST_DIV      = 5;
	localparam int ST_LAST_DIV = ST_DIV + Q_W - 1;
	localparam int ST_OUT      = ST_LAST_DIV + 1;
	localparam int NUM_ST      = ST_OUT;

endpackage

FILE: hw/rtl/tam_scale.sv
// ----------------------------------------------------------------------------
// tam_scale
// Scales one axis level to a signed fixed point force: floor(level * K *
// 2^FRAC_BITS / 254), negated when its flag is set.
// ----------------------------------------------------------------------------
module tam_scale import tam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int K         = K_SURGE_SWAY
) (
	input  logic                       clk,
	input  logic [NUM_ST:1]            en,
	input  logic [LEVEL_W-1:0]         level,
	input  logic                       neg,
	output logic signed [FRAC_BITS+11:0] axis_s1
);

	localparam int AW = FRAC_BITS + 12;
	localparam int CW = FRAC_BITS + 20;
	localparam int PW = CW + LEVEL_W;
	// reciprocal rounded up: error stays below one step of the true quotient
	localparam longint unsigned RECIP_L =
		((64'(K)) << (FRAC_BITS + RECIP_SH)) / 64'(LEVEL_DEN) + 64'd1;
	localparam logic [CW-1:0] RECIP = RECIP_L[CW-1:0];

	logic [PW-1:0]        prod;
	logic [AW-1:0]        mag_ext;
	logic signed [AW-1:0] axis_d;

	always_comb begin
		prod    = PW'(level) * PW'(RECIP);
		mag_ext = {1'b0, prod[PW-1:RECIP_SH]};
		axis_d  = neg ? -$signed(mag_ext) : $signed(mag_ext);
	end

	always_ff @(posedge clk) begin
		if (en[ST_SCALE]) begin
			axis_s1 <= axis_d;
		end
	end

endmodule

FILE: hw/rtl/tam_mix.sv
// ----------------------------------------------------------------------------
// tam_mix
// Mixes the scaled axes into six thruster sums, takes their magnitudes and
// finds the peak of each group and whether it exceeds the force limit.
// ----------------------------------------------------------------------------
module tam_mix import tam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic [NUM_ST:1]                       en,
	input  logic [MF_W-1:0]                       thrust_cap,
	input  logic signed [FRAC_BITS+11:0]          sx,
	input  logic signed [FRAC_BITS+11:0]          sy,
	input  logic signed [FRAC_BITS+11:0]          tp,
	input  logic signed [FRAC_BITS+11:0]          ty,
	input  logic signed [FRAC_BITS+11:0]          fz,
	output logic [NUM_LANES-1:0][FRAC_BITS+12:0]  mag_s3,
	output logic [NUM_LANES-1:0]                  neg_s3,
	output logic [FRAC_BITS+12:0]                 peak_h_s4,
	output logic [FRAC_BITS+12:0]                 peak_v_s4,
	output logic                                  sat_h_s4,
	output logic                                  sat_v_s4
);

	localparam int SW = FRAC_BITS + 14;
	localparam int MW = FRAC_BITS + 13;

	logic signed [SW-1:0] sx_e, sy_e, ty2, tp2, fz_e;
	logic signed [SW-1:0] sum_d  [NUM_LANES];
	logic signed [SW-1:0] sum_s2 [NUM_LANES];
	logic [SW-1:0]        abs_d  [NUM_LANES];
	logic [MW-1:0]        mx01, mx23, peak_h_d, peak_v_d, lim_h, lim_v;

	// horizontal sums at scale 2^(FRAC_BITS+2), vertical at 2^(FRAC_BITS+1)
	always_comb begin
		sx_e = SW'(sx);
		sy_e = SW'(sy);
		fz_e = SW'(fz);
		ty2  = SW'(ty) <<< 1;
		tp2  = SW'(tp) <<< 1;
		sum_d[L_FR] =  sx_e + sy_e + ty2;
		sum_d[L_FL] =  sx_e - sy_e - ty2;
		sum_d[L_BR] = -sx_e + sy_e - ty2;
		sum_d[L_BL] = -sx_e - sy_e + ty2;
		sum_d[L_V1] =  fz_e + tp2;
		sum_d[L_V2] =  fz_e - tp2;
	end

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				sum_s2[i] <= sum_d[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			abs_d[i] = sum_s2[i][SW-1] ? SW'(-sum_s2[i]) : SW'(sum_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_MAG]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				mag_s3[i] <= abs_d[i][MW-1:0];
				neg_s3[i] <= sum_s2[i][SW-1];
			end
		end
	end

	always_comb begin
		mx01     = (mag_s3[L_FR] > mag_s3[L_FL]) ? mag_s3[L_FR] : mag_s3[L_FL];
		mx23     = (mag_s3[L_BR] > mag_s3[L_BL]) ? mag_s3[L_BR] : mag_s3[L_BL];
		peak_h_d = (mx01 > mx23) ? mx01 : mx23;
		peak_v_d = (mag_s3[L_V1] > mag_s3[L_V2]) ? mag_s3[L_V1] : mag_s3[L_V2];
		lim_h    = MW'({thrust_cap, {(FRAC_BITS + 2){1'b0}}});
		lim_v    = MW'({thrust_cap, {(FRAC_BITS + 1){1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en[ST_PEAK]) begin
			peak_h_s4 <= peak_h_d;
			peak_v_s4 <= peak_v_d;
			sat_h_s4  <= peak_h_d > lim_h;
			sat_v_s4  <= peak_v_d > lim_v;
		end
	end

endmodule

FILE: hw/rtl/tam_lane.sv
// ----------------------------------------------------------------------------
// tam_lane
// One thruster lane: either shifts its sum down to the output scale or, in a
// saturated group, divides sum * thrust cap by the group peak in a pipelined
// restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tam_lane import tam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SHIFT     = FRAC_BITS_DEF + 2
) (
	input  logic                     clk,
	input  logic [NUM_ST:1]          en,
	input  logic [MF_W-1:0]          thrust_cap,
	input  logic [FRAC_BITS+12:0]    mag_s3,
	input  logic                     neg_s3,
	input  logic [FRAC_BITS+12:0]    peak_s4,
	input  logic                     sat_s4,
	output logic signed [OUT_W-1:0]  result
);

	localparam int MW = FRAC_BITS + 13;
	localparam int NW = MW + MF_W;

	logic [NW-1:0]  num_s4;
	logic [Q_W-1:0] unsat_s4;
	logic           neg_s4;

	// index j of these arrays holds stage ST_DIV + j
	logic [NW-1:0]  rem_sn   [Q_W];
	logic [Q_W-1:0] quo_sn   [Q_W];
	logic [MW-1:0]  den_sn   [Q_W];
	logic [Q_W-1:0] unsat_sn [Q_W];
	logic           sat_sn   [Q_W];
	logic           neg_sn   [Q_W];

	logic [Q_W-1:0] mag_out;

	always_ff @(posedge clk) begin
		if (en[ST_PEAK]) begin
			num_s4   <= NW'(mag_s3) * NW'(thrust_cap);
			unsat_s4 <= mag_s3[SHIFT+Q_W-1:SHIFT];
			neg_s4   <= neg_s3;
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int BIT = Q_W - 1 - j;

		logic [NW-1:0]  rem_in, trial, rem_nx;
		logic [Q_W-1:0] quo_in, quo_nx;
		logic [MW-1:0]  den_in;
		logic [Q_W-1:0] unsat_in;
		logic           sat_in, neg_in, take;

		if (j == 0) begin : g_first
			assign rem_in   = num_s4;
			assign quo_in   = '0;
			assign den_in   = peak_s4;
			assign unsat_in = unsat_s4;
			assign sat_in   = sat_s4;
			assign neg_in   = neg_s4;
		end else begin : g_next
			assign rem_in   = rem_sn[j-1];
			assign quo_in   = quo_sn[j-1];
			assign den_in   = den_sn[j-1];
			assign unsat_in = unsat_sn[j-1];
			assign sat_in   = sat_sn[j-1];
			assign neg_in   = neg_sn[j-1];
		end

		always_comb begin
			trial       = NW'(den_in) << BIT;
			take        = rem_in >= trial;
			rem_nx      = take ? rem_in - trial : rem_in;
			quo_nx      = quo_in;
			quo_nx[BIT] = take;
		end

		always_ff @(posedge clk) begin
			if (en[ST_DIV+j]) begin
				rem_sn[j]        <= rem_nx;
				quo_sn[j]        <= quo_nx;
				den_sn[j]        <= den_in;
				unsat_sn[j]      <= unsat_in;
				sat_sn[j]        <= sat_in;
				neg_sn[j]        <= neg_in;
			end
		end
	end

	// truncation toward zero: magnitude first, sign applied last
	always_comb begin
		mag_out = sat_sn[Q_W-1] ? quo_sn[Q_W-1] : unsat_sn[Q_W-1];
		result  = neg_sn[Q_W-1] ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
	end

endmodule

FILE: hw/rtl/thruster_allocation_mixer_top.sv
// ----------------------------------------------------------------------------
// thruster_allocation_mixer_top
// Six-thruster allocation mixer with per-group desaturation.
// ----------------------------------------------------------------------------
// Takes one joystick command per clock while the output side is not stalled
// and presents six thrust commands through 13 register stages in all. The
// eight-stage restoring divider in each thruster lane (one quotient bit per
// stage) sits behind the axis scaling, mixing, magnitude and group peak
// stages, with the output register last. Every stage holds its own valid bit,
// so bubbles close up under backpressure and the input keeps being taken while
// a result waits at the output, until all 13 stages hold a command. The thrust
// cap may be written at any time the block is empty; cfg_ready is always high.
module thruster_allocation_mixer_top import tam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// surge_level, sway_level, pitch_level, yaw_level, heave_level
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// sign_bits
	input  logic [SIGN_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// thrust_fwd_right, thrust_fwd_left, thrust_back_right, thrust_back_left,
	// thrust_vertical_one, thrust_vertical_two, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MF_W-1:0]       cfg_data
);

	localparam int AW = FRAC_BITS + 12;
	localparam int MW = FRAC_BITS + 13;

	logic [NUM_ST:1]  valid_q;
	logic [NUM_ST:1]  en;
	logic [MF_W-1:0]  thrust_cap_q;

	logic signed [AW-1:0] sx, sy, tp, ty, fz;
	logic [NUM_LANES-1:0][MW-1:0]    mag_s3;
	logic [NUM_LANES-1:0]            neg_s3;
	logic [MW-1:0]                   peak_h_s4, peak_v_s4;
	logic                            sat_h_s4, sat_v_s4;
	logic [NUM_LANES-1:0][OUT_W-1:0] lane_res;
	logic [OUT_DATA_W-1:0]           tdata_d;
	logic [OUT_DATA_W-1:0]           tdata_q;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en[NUM_ST] = !valid_q[NUM_ST] || m_axis_tready;
		for (int k = NUM_ST - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NUM_ST; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_cap_q <= MF_RESET;
		end else if (cfg_valid) begin
			thrust_cap_q <= cfg_data;
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = en[1];
	assign m_axis_tvalid = valid_q[NUM_ST];
	assign m_axis_tdata  = tdata_q;

	tam_scale #(.FRAC_BITS(FRAC_BITS), .K(K_SURGE_SWAY)) u_scale_surge (
		.clk(clk), .en(en), .level(s_axis_tdata[0*LEVEL_W +: LEVEL_W]),
		.neg(s_axis_tuser[SB_SURGE]), .axis_s1(sx)
	);
	tam_scale #(.FRAC_BITS(FRAC_BITS), .K(K_SURGE_SWAY)) u_scale_sway (
		.clk(clk), .en(en), .level(s_axis_tdata[1*LEVEL_W +: LEVEL_W]),
		.neg(s_axis_tuser[SB_SWAY]), .axis_s1(sy)
	);
	tam_scale #(.FRAC_BITS(FRAC_BITS), .K(K_PITCH)) u_scale_pitch (
		.clk(clk), .en(en), .level(s_axis_tdata[2*LEVEL_W +: LEVEL_W]),
		.neg(s_axis_tuser[SB_PITCH]), .axis_s1(tp)
	);
	tam_scale #(.FRAC_BITS(FRAC_BITS), .K(K_YAW_HEAVE)) u_scale_yaw (
		.clk(clk), .en(en), .level(s_axis_tdata[3*LEVEL_W +: LEVEL_W]),
		.neg(s_axis_tuser[SB_YAW]), .axis_s1(ty)
	);
	tam_scale #(.FRAC_BITS(FRAC_BITS), .K(K_YAW_HEAVE)) u_scale_heave (
		.clk(clk), .en(en), .level(s_axis_tdata[4*LEVEL_W +: LEVEL_W]),
		.neg(s_axis_tuser[SB_HEAVE]), .axis_s1(fz)
	);

	tam_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk(clk), .en(en), .thrust_cap(thrust_cap_q),
		.sx(sx), .sy(sy), .tp(tp), .ty(ty), .fz(fz),
		.mag_s3(mag_s3), .neg_s3(neg_s3),
		.peak_h_s4(peak_h_s4), .peak_v_s4(peak_v_s4),
		.sat_h_s4(sat_h_s4), .sat_v_s4(sat_v_s4)
	);

	for (genvar i = 0; i < NUM_H; i++) begin : g_hlane
		tam_lane #(.FRAC_BITS(FRAC_BITS), .SHIFT(FRAC_BITS + 2)) u_lane (
			.clk(clk), .en(en), .thrust_cap(thrust_cap_q),
			.mag_s3(mag_s3[i]), .neg_s3(neg_s3[i]),
			.peak_s4(peak_h_s4), .sat_s4(sat_h_s4), .result(lane_res[i])
		);
	end

	for (genvar i = 0; i < NUM_V; i++) begin : g_vlane
		tam_lane #(.FRAC_BITS(FRAC_BITS), .SHIFT(FRAC_BITS + 1)) u_lane (
			.clk(clk), .en(en), .thrust_cap(thrust_cap_q),
			.mag_s3(mag_s3[NUM_H+i]), .neg_s3(neg_s3[NUM_H+i]),
			.peak_s4(peak_v_s4), .sat_s4(sat_v_s4), .result(lane_res[NUM_H+i])
		);
	end

	// merge the lanes into one output transaction
	always_comb begin
		tdata_d = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			tdata_d[i*OUT_W +: OUT_W] = lane_res[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			tdata_q <= tdata_d;
		end
	end

endmodule

FILE: hw/rtl/tam_chk.sv
// ----------------------------------------------------------------------------
// tam_chk
// Port-level checks for the thruster allocation mixer, bound to the top.
// ----------------------------------------------------------------------------
module tam_chk import tam_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic bad_field;

	// the most negative 9-bit code is never a legal thrust
	always_comb begin
		bad_field = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (m_axis_tdata[i*OUT_W +: OUT_W] == {1'b1, {(OUT_W - 1){1'b0}}}) begin
				bad_field = 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped before transaction completed");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while output side was free");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !bad_field)
		else $error("thrust out of range");

endmodule

bind thruster_allocation_mixer_top tam_chk u_tam_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

FILE: tb/sv/tb_thruster_allocation_mixer_top.sv
// ----------------------------------------------------------------------------
// tb_thruster_allocation_mixer_top
// Self-checking bench for the thruster allocation mixer. A directed table of
// joystick commands (single axes at full scale, negated axes, levels of 255,
// alternating bit patterns) is sent first, then random commands in phases
// that change the thrust cap and the idling on both stream sides, one of them
// with a long output hold-off. Every output transaction is compared lane by lane
// with the table's typed thrusts or a fixed-point model of mix and desaturation.
// ----------------------------------------------------------------------------
module tb_thruster_allocation_mixer_top;
	import tam_pkg::*;

	localparam int FRAC         = FRAC_BITS_DEF;
	localparam int H_SHIFT      = FRAC + 2;
	localparam int V_SHIFT      = FRAC + 1;
	localparam int PHASE_ITEMS  = 80;
	localparam int NUM_PHASES   = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	typedef logic [NUM_AXES-1:0][LEVEL_W-1:0] level_vec_t;
	typedef logic [NUM_LANES-1:0][OUT_W-1:0]  thrust_vec_t;
	typedef struct packed {
		level_vec_t        lv;
		logic [SIGN_W-1:0] sb;
		logic              typed;
		thrust_vec_t       want;
	} cmd_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// surge_level, sway_level, pitch_level, yaw_level, heave_level
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// sign_bits
	logic [SIGN_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// thrust_fwd_right, thrust_fwd_left, thrust_back_right, thrust_back_left,
	// thrust_vertical_one, thrust_vertical_two, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MF_W-1:0]       cfg_data;

	thrust_vec_t     thrust_q[$];
	logic [MF_W-1:0] limit_copy;
	int              idle_pct;
	int              stall_pct;
	int              hold_requests;
	int              fail_count = 0;
	int              cycle_count = 0;

	string lane_name [NUM_LANES] = '{"fwd_right", "fwd_left", "back_right",
		"back_left", "vertical_one", "vertical_two"};

	thruster_allocation_mixer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// thrust prediction
	// ------------------------------------------------------------------
	function automatic longint axis_force(logic [LEVEL_W-1:0] level, int k, logic neg);
		longint m;
		m = (longint'(level) * longint'(k) * (longint'(1) << FRAC)) / LEVEL_DEN;
		return neg ? -m : m;
	endfunction

	function automatic longint magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// sum is at scale 2^shift; shrink by cap / peak when the group saturates
	function automatic logic [OUT_W-1:0] limit_lane(longint sum, longint peak,
			logic [MF_W-1:0] mf, int shift);
		longint r;
		if (peak > (longint'(mf) << shift)) begin
			r = (sum * longint'(mf)) / peak;
		end else begin
			r = sum / (longint'(1) << shift);
		end
		return r[OUT_W-1:0];
	endfunction

	function automatic thrust_vec_t predict_thrusts(level_vec_t lv, logic [SIGN_W-1:0] sb,
			logic [MF_W-1:0] mf);
		longint      fx, fy, tp, ty, fz, hpeak, vpeak;
		longint      h [NUM_H];
		longint      v [NUM_V];
		thrust_vec_t t;
		fx = axis_force(lv[SB_SURGE], K_SURGE_SWAY, sb[SB_SURGE]);
		fy = axis_force(lv[SB_SWAY],  K_SURGE_SWAY, sb[SB_SWAY]);
		tp = axis_force(lv[SB_PITCH], K_PITCH,      sb[SB_PITCH]);
		ty = axis_force(lv[SB_YAW],   K_YAW_HEAVE,  sb[SB_YAW]);
		fz = axis_force(lv[SB_HEAVE], K_YAW_HEAVE,  sb[SB_HEAVE]);
		h[L_FR] =  fx + fy + 2 * ty;
		h[L_FL] =  fx - fy - 2 * ty;
		h[L_BR] = -fx + fy - 2 * ty;
		h[L_BL] = -fx - fy + 2 * ty;
		v[0] = fz + 2 * tp;
		v[1] = fz - 2 * tp;
		hpeak = 0;
		vpeak = 0;
		for (int i = 0; i < NUM_H; i++) if (magnitude(h[i]) > hpeak) hpeak = magnitude(h[i]);
		for (int i = 0; i < NUM_V; i++) if (magnitude(v[i]) > vpeak) vpeak = magnitude(v[i]);
		for (int i = 0; i < NUM_H; i++) t[L_FR + i] = limit_lane(h[i], hpeak, mf, H_SHIFT);
		for (int i = 0; i < NUM_V; i++) t[L_V1 + i] = limit_lane(v[i], vpeak, mf, V_SHIFT);
		return t;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic cmd_row_t mk_cmd(int su, int sw, int pi, int ya, int he, int sb,
			bit typed = 1'b0, int fr = 0, int fl = 0, int br = 0, int bl = 0,
			int v1 = 0, int v2 = 0);
		cmd_row_t r;
		r.lv[SB_SURGE] = su[LEVEL_W-1:0];
		r.lv[SB_SWAY]  = sw[LEVEL_W-1:0];
		r.lv[SB_PITCH] = pi[LEVEL_W-1:0];
		r.lv[SB_YAW]   = ya[LEVEL_W-1:0];
		r.lv[SB_HEAVE] = he[LEVEL_W-1:0];
		r.sb           = sb[SIGN_W-1:0];
		r.typed        = typed;
		r.want[L_FR]   = fr[OUT_W-1:0];
		r.want[L_FL]   = fl[OUT_W-1:0];
		r.want[L_BR]   = br[OUT_W-1:0];
		r.want[L_BL]   = bl[OUT_W-1:0];
		r.want[L_V1]   = v1[OUT_W-1:0];
		r.want[L_V2]   = v2[OUT_W-1:0];
		return r;
	endfunction

	// full scale and zero turn up far more often than a flat spread would give
	function automatic logic [LEVEL_W-1:0] pick_level();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return LEVEL_W'(254);
			2: return '1;
			default: return LEVEL_W'($urandom_range(0, 254));
		endcase
	endfunction

	task automatic send_command(level_vec_t lv, logic [SIGN_W-1:0] sb, logic typed,
			thrust_vec_t want);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= lv;
		s_axis_tuser  <= sb;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		thrust_q.push_back(typed ? want : predict_thrusts(lv, sb, limit_copy));
	endtask

	// only called with the stream side quiet and every result back
	task automatic write_thrust_cap(logic [MF_W-1:0] value);
		while (thrust_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		limit_copy = cfg_data;
		cfg_valid <= 1'b0;
	endtask

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) $display("%s", msg);
	endtask

	// ------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------
	initial begin
		cmd_row_t          rows[$];
		level_vec_t        lv;
		logic [SIGN_W-1:0] sb;
		int                style;
		int                keep;
		int                phase_limit [NUM_PHASES] = '{1, 255, -1, 100, -1, 255};
		int                phase_idle  [NUM_PHASES] = '{0, 65, 0, 33, 0, 33};
		int                phase_stall [NUM_PHASES] = '{0, 0, 65, 33, 0, 33};

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		hold_requests = 0;
		limit_copy    = MF_RESET;

		// single axes at full scale land exactly on the reset limit of 255
		rows.push_back(mk_cmd(0, 0, 0, 0, 0, 0, 1));
		rows.push_back(mk_cmd(254, 0, 0, 0, 0, 0, 1, 255, 255, -255, -255));
		rows.push_back(mk_cmd(254, 0, 0, 0, 0, 1 << SB_SURGE, 1, -255, -255, 255, 255));
		rows.push_back(mk_cmd(0, 254, 0, 0, 0, 0, 1, 255, -255, 255, -255));
		rows.push_back(mk_cmd(0, 254, 0, 0, 0, 1 << SB_SWAY, 1, -255, 255, -255, 255));
		rows.push_back(mk_cmd(0, 0, 0, 254, 0, 0, 1, 255, -255, -255, 255));
		rows.push_back(mk_cmd(0, 0, 0, 254, 0, 1 << SB_YAW, 1, -255, 255, 255, -255));
		rows.push_back(mk_cmd(0, 0, 254, 0, 0, 0, 1, 0, 0, 0, 0, 255, -255));
		rows.push_back(mk_cmd(0, 0, 254, 0, 0, 1 << SB_PITCH, 1, 0, 0, 0, 0, -255, 255));
		rows.push_back(mk_cmd(0, 0, 0, 0, 254, 0, 1, 0, 0, 0, 0, 255, 255));
		rows.push_back(mk_cmd(0, 0, 0, 0, 254, 1 << SB_HEAVE, 1, 0, 0, 0, 0, -255, -255));
		// combined axes go through the model
		rows.push_back(mk_cmd(254, 254, 254, 254, 254, 0));
		rows.push_back(mk_cmd(254, 254, 254, 254, 254, (1 << SIGN_W) - 1));
		rows.push_back(mk_cmd(255, 255, 255, 255, 255, 0));
		rows.push_back(mk_cmd(255, 255, 255, 255, 255, (1 << SIGN_W) - 1));
		rows.push_back(mk_cmd(1, 1, 1, 1, 1, 0));
		rows.push_back(mk_cmd(8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 5'h0a));
		rows.push_back(mk_cmd(8'haa, 8'haa, 8'haa, 8'haa, 8'haa, 5'h15));
		rows.push_back(mk_cmd(127, 3, 200, 64, 31, 5'h09));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_command(rows[i].lv, rows[i].sb, rows[i].typed, rows[i].want);
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_thrust_cap((phase_limit[p] < 0) ? MF_W'($urandom_range(1, 255))
				: MF_W'(phase_limit[p]));
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			// output held back for a long stretch while commands keep coming
			if (p == 4) hold_requests++;
			repeat (PHASE_ITEMS) begin
				style = $urandom_range(0, 9);
				for (int a = 0; a < NUM_AXES; a++) begin
					lv[a] = (style == 0) ? LEVEL_W'($urandom_range(0, 3)) : pick_level();
				end
				if (style == 1) begin
					keep = $urandom_range(0, NUM_AXES - 1);
					for (int a = 0; a < NUM_AXES; a++) if (a != keep) lv[a] = '0;
				end
				sb = $urandom_range(0, (1 << SIGN_W) - 1);
				send_command(lv, sb, 1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
		end

		while (thrust_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	initial begin
		int seen;
		int held;
		seen = 0;
		held = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != seen) begin
				seen = hold_requests;
				held = HOLD_CYCLES;
			end
			if (held > 0) begin
				held--;
				m_axis_tready <= 1'b0;
			end else if (stall_pct == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		thrust_vec_t want;
		logic [OUT_W-1:0] got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (thrust_q.size() == 0) begin
				note_failure($sformatf("thrust transaction with none pending: %h", m_axis_tdata));
			end else begin
				want = thrust_q.pop_front();
				for (int l = 0; l < NUM_LANES; l++) begin
					got = m_axis_tdata[l * OUT_W +: OUT_W];
					if (got !== want[l]) begin
						note_failure($sformatf("thrust %s: expected %0d, got %0d",
							lane_name[l], $signed(want[l]), $signed(got)));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

FILE: sim.f
hw/rtl/tam_pkg.sv
hw/rtl/tam_scale.sv
hw/rtl/tam_mix.sv
hw/rtl/tam_lane.sv
hw/rtl/thruster_allocation_mixer_top.sv
hw/rtl/tam_chk.sv
tb/sv/tb_thruster_allocation_mixer_top.sv
